// File: rtl/hsm_pkg.sv
// Shared constants, types and helper functions for the heightmap slope mask.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package hsm_pkg;

	// Raster geometry.
	localparam int ROW_MAX   = 4096;
	localparam int COL_W     = $clog2(ROW_MAX);
	localparam int CNT_W     = COL_W + 1;
	localparam int ROW_LIMIT = 4096;

	// Sample and register widths.
	localparam int SAMPLE_W = 16;
	localparam int FIX_W    = 16;
	localparam int IDX_W    = 3;

	// Register indexes of the configuration port.
	localparam logic [IDX_W-1:0] REG_ROW_LENGTH   = 3'd0;
	localparam logic [IDX_W-1:0] REG_ROW_COUNT    = 3'd1;
	localparam logic [IDX_W-1:0] REG_SPACING_X    = 3'd2;
	localparam logic [IDX_W-1:0] REG_SPACING_Z    = 3'd3;
	localparam logic [IDX_W-1:0] REG_HEIGHT_SCALE = 3'd4;

	// Gradient divider: Q.12 quotient, saturated at 2^28.
	localparam int GRAD_FRAC  = 12;
	localparam int GRAD_STEPS = 28;
	localparam int SAT_SHIFT  = GRAD_STEPS - GRAD_FRAC;
	localparam int G_W        = GRAD_STEPS + 1;
	localparam int GRAD_LAT   = GRAD_STEPS + 3;

	// Reciprocal square root: 2^56 / S, then an integer square root.
	localparam int SQ_W        = 2 * G_W;
	localparam int SUM_W       = SQ_W;
	localparam int RECIP_STEPS = 33;
	localparam int RECIP_SHIFT = 56;
	localparam int SQRT_STEPS  = 17;
	localparam int RSQRT_LAT   = RECIP_STEPS + SQRT_STEPS + 3;

	// Stages between the line buffer output and the final result.
	localparam int PIPE_LAT = GRAD_LAT + RSQRT_LAT;

	// Per-pixel control decided when the sample is accepted.
	typedef struct packed {
		logic emit;
		logic drain;
		logic has_left;
		logic has_right;
		logic has_top;
		logic row_end;
		logic frame_end;
	} pix_ctrl_t;

	// Flags that ride alongside a result.
	typedef struct packed {
		logic row_end;
		logic frame_end;
	} out_tag_t;

	// Difference magnitudes and span flags handed to the gradient units.
	typedef struct packed {
		logic [SAMPLE_W-1:0] dh;
		logic                h2;
		logic [SAMPLE_W-1:0] dv;
		logic                v2;
	} grad_in_t;

	// Magnitude of the difference of two signed samples.
	function automatic logic [SAMPLE_W-1:0] abs_diff(
		input logic [SAMPLE_W-1:0] a,
		input logic [SAMPLE_W-1:0] b
	);
		logic [SAMPLE_W:0] d;
		d = {a[SAMPLE_W-1], a} - {b[SAMPLE_W-1], b};
		if (d[SAMPLE_W]) begin
			abs_diff = SAMPLE_W'(~d + 1'b1);
		end else begin
			abs_diff = d[SAMPLE_W-1:0];
		end
	endfunction

endpackage

`default_nettype wire

// File: rtl/heightmap_slope_mask.sv
// Heightmap slope mask: raster counters, configuration, result queue.
// Depends on hsm_pkg, hsm_line_buf, hsm_grad and hsm_rsqrt.
//
// Usage: height samples enter on the input channel in raster order, one word
// per accepted beat (in_valid high, in_stall low). The first row of a frame
// only fills the line buffer; from the second row on each word yields the
// slope of the pixel one row above. After the last row, row_length words with
// flush set drain the final output row. A flush word mid-frame, or a sample
// word while draining, is dropped. row_end and frame_end mark the last pixel
// of a row and of the frame.
// One word is taken every cycle while in_stall is low. The depth is set by
// the two pipelined restoring dividers and the pipelined square root.
// Configuration is written through cfg_write, cfg_index and cfg_data; the
// user must do so only while the block is idle; the block does not check it.
// Reset clears the counters and pipeline valid bits and loads the register
// defaults. When the receiver stalls, the pipeline runs one more word into a
// skid register and then raises in_stall; nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module heightmap_slope_mask (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_write,
	input  wire logic [hsm_pkg::IDX_W-1:0]    cfg_index,
	input  wire logic [hsm_pkg::FIX_W-1:0]    cfg_data,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [hsm_pkg::SAMPLE_W-1:0] height_sample,
	input  wire logic                         flush,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic      [hsm_pkg::FIX_W-1:0]    slope,
	output logic                              row_end,
	output logic                              frame_end
);
	import hsm_pkg::*;

	// Configuration registers.
	logic [CNT_W-1:0] row_length_q;
	logic [CNT_W-1:0] row_count_q;
	logic [FIX_W-1:0] spacing_x_q;
	logic [FIX_W-1:0] spacing_z_q;
	logic [FIX_W-1:0] height_scale_q;

	logic [COL_W-1:0] col_q;
	logic [CNT_W-1:0] row_q;

	logic             en;
	logic             in_acc;
	logic             take;
	logic             drain;
	logic             last_col;
	logic [CNT_W-1:0] w_eff;
	logic [CNT_W-1:0] h_eff;
	logic [FIX_W-1:0] scale_mag;
	pix_ctrl_t        ctrl;

	logic             v_s2;
	out_tag_t         tag_s2;
	grad_in_t         grad_s2;
	logic [G_W-1:0]   gx;
	logic [G_W-1:0]   gz;
	logic [FIX_W-1:0] slope_d;

	logic             v_dly_q   [1:PIPE_LAT];
	out_tag_t         tag_dly_q [1:PIPE_LAT];

	logic             out_v_q;
	logic [FIX_W-1:0] out_slope_q;
	out_tag_t         out_tag_q;
	logic             skid_v_q;
	logic [FIX_W-1:0] skid_slope_q;
	out_tag_t         skid_tag_q;
	logic             take_out;
	logic             last_v;

	// The pipeline moves unless the skid register is occupied.
	assign en       = !skid_v_q;
	assign in_stall = skid_v_q;
	assign in_acc   = in_valid && !in_stall;

	// Effective frame size and the scale magnitude.
	always_comb begin
		if (row_length_q == '0) begin
			w_eff = CNT_W'(1);
		end else if (row_length_q > CNT_W'(ROW_MAX)) begin
			w_eff = CNT_W'(ROW_MAX);
		end else begin
			w_eff = row_length_q;
		end
		if (row_count_q == '0) begin
			h_eff = CNT_W'(1);
		end else if (row_count_q > CNT_W'(ROW_LIMIT)) begin
			h_eff = CNT_W'(ROW_LIMIT);
		end else begin
			h_eff = row_count_q;
		end
		scale_mag = height_scale_q[FIX_W-1] ? FIX_W'(~height_scale_q + 1'b1)
			: height_scale_q;
	end

	// Word classification and border flags.
	always_comb begin
		drain          = row_q >= h_eff;
		take           = in_acc && (flush == drain);
		last_col       = ({1'b0, col_q} + 1'b1) >= w_eff;
		ctrl.emit      = row_q != '0;
		ctrl.drain     = drain;
		ctrl.has_left  = col_q != '0;
		ctrl.has_right = !last_col;
		ctrl.has_top   = row_q >= CNT_W'(2);
		ctrl.row_end   = last_col;
		ctrl.frame_end = last_col && drain;
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_length_q   <= CNT_W'(ROW_MAX);
			row_count_q    <= CNT_W'(ROW_LIMIT);
			spacing_x_q    <= FIX_W'(256);
			spacing_z_q    <= FIX_W'(256);
			height_scale_q <= FIX_W'(256);
		end else if (cfg_write) begin
			case (cfg_index)
				REG_ROW_LENGTH:   row_length_q   <= cfg_data[CNT_W-1:0];
				REG_ROW_COUNT:    row_count_q    <= cfg_data[CNT_W-1:0];
				REG_SPACING_X:    spacing_x_q    <= cfg_data;
				REG_SPACING_Z:    spacing_z_q    <= cfg_data;
				REG_HEIGHT_SCALE: height_scale_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Raster position counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (take) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= drain ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	hsm_line_buf u_line_buf (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.take    (take),
		.col     (col_q),
		.sample  (height_sample),
		.ctrl    (ctrl),
		.v_s2    (v_s2),
		.tag_s2  (tag_s2),
		.grad_s2 (grad_s2)
	);

	hsm_grad u_grad_x (
		.clk       (clk),
		.en        (en),
		.diff      (grad_s2.dh),
		.span2     (grad_s2.h2),
		.spacing   (spacing_x_q),
		.scale_mag (scale_mag),
		.g         (gx)
	);

	hsm_grad u_grad_z (
		.clk       (clk),
		.en        (en),
		.diff      (grad_s2.dv),
		.span2     (grad_s2.v2),
		.spacing   (spacing_z_q),
		.scale_mag (scale_mag),
		.g         (gz)
	);

	hsm_rsqrt u_rsqrt (
		.clk   (clk),
		.en    (en),
		.gx    (gx),
		.gz    (gz),
		.slope (slope_d)
	);

	// Valid bits and flags follow the arithmetic pipeline.
	always_ff @(posedge clk) begin
		if (en) begin
			tag_dly_q[1] <= tag_s2;
			for (int k = 1; k < PIPE_LAT; k++) begin
				tag_dly_q[k+1] <= tag_dly_q[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= PIPE_LAT; k++) begin
				v_dly_q[k] <= 1'b0;
			end
		end else if (en) begin
			v_dly_q[1] <= v_s2;
			for (int k = 1; k < PIPE_LAT; k++) begin
				v_dly_q[k+1] <= v_dly_q[k];
			end
		end
	end

	assign last_v   = v_dly_q[PIPE_LAT];
	assign take_out = out_v_q && !out_stall;

	// Output register with a skid register behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (en && last_v) begin
			if (!out_v_q || take_out) begin
				out_v_q <= 1'b1;
			end else begin
				skid_v_q <= 1'b1;
			end
		end else if (skid_v_q && take_out) begin
			skid_v_q <= 1'b0;
		end else if (take_out) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en && last_v) begin
			if (!out_v_q || take_out) begin
				out_slope_q <= slope_d;
				out_tag_q   <= tag_dly_q[PIPE_LAT];
			end else begin
				skid_slope_q <= slope_d;
				skid_tag_q   <= tag_dly_q[PIPE_LAT];
			end
		end else if (skid_v_q && take_out) begin
			out_slope_q <= skid_slope_q;
			out_tag_q   <= skid_tag_q;
		end
	end

	assign out_valid = out_v_q;
	assign slope     = out_slope_q;
	assign row_end   = out_tag_q.row_end;
	assign frame_end = out_tag_q.frame_end;

	// The skid register only holds a word behind a full output register.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid register full while output register empty");

	// The skid register fills only after the receiver stalled a result.
	a_skid_fill_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_v_q) |-> $past(out_v_q && out_stall))
		else $error("skid register filled without a stalled result");

	// A frame end is always the last pixel of a row.
	a_frame_end_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && out_tag_q.frame_end |-> out_tag_q.row_end)
		else $error("frame end without row end");

	// The row counter never passes the largest frame height, ROW_LIMIT.
	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		row_q <= CNT_W'(ROW_LIMIT))
		else $error("row counter out of range");

endmodule

`default_nettype wire

// File: rtl/hsm_line_buf.sv
// Two-row line buffer with neighbor selection and difference stage.
// Depends on hsm_pkg; holds both stored rows in one two-read, one-write memory.
`timescale 1ns / 1ps
`default_nettype none

module hsm_line_buf (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire logic                          take,
	input  wire logic [hsm_pkg::COL_W-1:0]     col,
	input  wire logic [hsm_pkg::SAMPLE_W-1:0]  sample,
	input  wire hsm_pkg::pix_ctrl_t            ctrl,
	output logic                               v_s2,
	output hsm_pkg::out_tag_t                  tag_s2,
	output hsm_pkg::grad_in_t                  grad_s2
);
	import hsm_pkg::*;

	localparam int WORD_W = 2 * SAMPLE_W;

	// Each word holds {upper row, middle row} for one column.
	logic [WORD_W-1:0] mem [0:ROW_MAX-1];

	logic [COL_W-1:0]    col_p1;
	logic                v_s1;
	logic [COL_W-1:0]    col_s1;
	logic [SAMPLE_W-1:0] sample_s1;
	pix_ctrl_t           ctrl_s1;
	logic [WORD_W-1:0]   rd0_s1;
	logic [WORD_W-1:0]   rd1_s1;
	logic                byp0_s1;
	logic                byp1_s1;
	logic [WORD_W-1:0]   byp_word_s1;
	logic [SAMPLE_W-1:0] last_center_q;

	logic [WORD_W-1:0]   word0;
	logic [WORD_W-1:0]   word1;
	logic [SAMPLE_W-1:0] center;
	logic [SAMPLE_W-1:0] top_raw;
	logic [SAMPLE_W-1:0] right_raw;
	logic [SAMPLE_W-1:0] left_n;
	logic [SAMPLE_W-1:0] right_n;
	logic [SAMPLE_W-1:0] top_n;
	logic [SAMPLE_W-1:0] bottom_n;
	logic [WORD_W-1:0]   wr_word;
	grad_in_t            grad_d;

	assign col_p1 = col + 1'b1;

	// A word written on the same edge as the read is taken from the bypass copy.
	always_comb begin
		word0     = byp0_s1 ? byp_word_s1 : rd0_s1;
		word1     = byp1_s1 ? byp_word_s1 : rd1_s1;
		center    = word0[SAMPLE_W-1:0];
		top_raw   = word0[WORD_W-1:SAMPLE_W];
		right_raw = word1[SAMPLE_W-1:0];
	end

	// The first row only fills the middle row; draining only shifts rows up.
	always_comb begin
		if (!ctrl_s1.emit) begin
			wr_word = {top_raw, sample_s1};
		end else if (ctrl_s1.drain) begin
			wr_word = {center, center};
		end else begin
			wr_word = {center, sample_s1};
		end
	end

	// Missing neighbors at a border fall back to the center pixel.
	always_comb begin
		left_n   = ctrl_s1.has_left  ? last_center_q : center;
		right_n  = ctrl_s1.has_right ? right_raw     : center;
		top_n    = ctrl_s1.has_top   ? top_raw       : center;
		bottom_n = !ctrl_s1.drain    ? sample_s1     : center;
		grad_d.h2 = ctrl_s1.has_left && ctrl_s1.has_right;
		grad_d.v2 = ctrl_s1.has_top && !ctrl_s1.drain;
		grad_d.dh = (ctrl_s1.has_left || ctrl_s1.has_right) ?
			abs_diff(right_n, left_n) : '0;
		grad_d.dv = (ctrl_s1.has_top || !ctrl_s1.drain) ?
			abs_diff(bottom_n, top_n) : '0;
	end

	// Line memory: two reads when a word is accepted, one write as it leaves stage one.
	always_ff @(posedge clk) begin
		if (en) begin
			if (take) begin
				rd0_s1 <= mem[col];
				rd1_s1 <= mem[col_p1];
			end
			if (v_s1) begin
				mem[col_s1] <= wr_word;
			end
		end
	end

	// Pipeline payload.
	always_ff @(posedge clk) begin
		if (en) begin
			col_s1      <= col;
			sample_s1   <= sample;
			ctrl_s1     <= ctrl;
			byp0_s1     <= v_s1 && (col_s1 == col);
			byp1_s1     <= v_s1 && (col_s1 == col_p1);
			byp_word_s1 <= wr_word;
			if (v_s1) begin
				last_center_q <= center;
			end
			grad_s2           <= grad_d;
			tag_s2.row_end    <= ctrl_s1.row_end;
			tag_s2.frame_end  <= ctrl_s1.frame_end;
		end
	end

	// Valid bits; first-row words stop here.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= take;
			v_s2 <= v_s1 && ctrl_s1.emit;
		end
	end

endmodule

`default_nettype wire

// File: rtl/hsm_grad.sv
// One axis of the gradient: scale multiply, then a pipelined restoring divider.
// Depends on hsm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hsm_grad (
	input  wire logic                         clk,
	input  wire logic                         en,
	input  wire logic [hsm_pkg::SAMPLE_W-1:0] diff,
	input  wire logic                         span2,
	input  wire logic [hsm_pkg::FIX_W-1:0]    spacing,
	input  wire logic [hsm_pkg::FIX_W-1:0]    scale_mag,
	output logic      [hsm_pkg::G_W-1:0]      g
);
	import hsm_pkg::*;

	localparam int PROD_W = SAMPLE_W + FIX_W;
	localparam int DEN_W  = FIX_W + 1;

	logic [FIX_W-1:0]      spacing_nz;
	logic [PROD_W-1:0]     prod_g1;
	logic [DEN_W-1:0]      den_g1;

	logic [DEN_W-1:0]      rem_q [0:GRAD_STEPS];
	logic [GRAD_STEPS-1:0] num_q [0:GRAD_STEPS];
	logic [GRAD_STEPS-1:0] quo_q [0:GRAD_STEPS];
	logic [DEN_W-1:0]      den_q [0:GRAD_STEPS];
	logic                  sat_q [0:GRAD_STEPS];

	logic [DEN_W-1:0]      nrem [0:GRAD_STEPS-1];
	logic                  nbit [0:GRAD_STEPS-1];
	logic [DEN_W:0]        trial [0:GRAD_STEPS-1];

	assign spacing_nz = (spacing == '0) ? FIX_W'(1) : spacing;

	// One quotient bit per stage.
	always_comb begin
		for (int k = 0; k < GRAD_STEPS; k++) begin
			trial[k] = {rem_q[k], num_q[k][GRAD_STEPS-1]};
			if (trial[k] >= {1'b0, den_q[k]}) begin
				nbit[k] = 1'b1;
				nrem[k] = DEN_W'(trial[k] - {1'b0, den_q[k]});
			end else begin
				nbit[k] = 1'b0;
				nrem[k] = trial[k][DEN_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// Product and divisor.
			prod_g1 <= PROD_W'(diff) * PROD_W'(scale_mag);
			den_g1  <= span2 ? {spacing_nz, 1'b0} : {1'b0, spacing_nz};

			// Overflow check and divider set-up.
			sat_q[0] <= {1'b0, prod_g1} >= {den_g1, {SAT_SHIFT{1'b0}}};
			rem_q[0] <= DEN_W'(prod_g1[PROD_W-1:SAT_SHIFT]);
			num_q[0] <= {prod_g1[SAT_SHIFT-1:0], {GRAD_FRAC{1'b0}}};
			quo_q[0] <= '0;
			den_q[0] <= den_g1;

			for (int k = 0; k < GRAD_STEPS; k++) begin
				rem_q[k+1] <= nrem[k];
				num_q[k+1] <= num_q[k] << 1;
				quo_q[k+1] <= {quo_q[k][GRAD_STEPS-2:0], nbit[k]};
				den_q[k+1] <= den_q[k];
				sat_q[k+1] <= sat_q[k];
			end

			// Saturate at 2^28.
			g <= sat_q[GRAD_STEPS] ? {1'b1, {GRAD_STEPS{1'b0}}}
				: {1'b0, quo_q[GRAD_STEPS]};
		end
	end

endmodule

`default_nettype wire

// File: rtl/hsm_rsqrt.sv
// Slope from the two gradients: squares, 2^56 / S, integer square root, 1 - x.
// Depends on hsm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hsm_rsqrt (
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic [hsm_pkg::G_W-1:0]  gx,
	input  wire logic [hsm_pkg::G_W-1:0]  gz,
	output logic      [hsm_pkg::FIX_W-1:0] slope
);
	import hsm_pkg::*;

	localparam int SQ_IN_W = 2 * SQRT_STEPS;
	localparam int SR_W    = SQRT_STEPS + 2;
	localparam logic [SUM_W-1:0] ONE_Q24 = SUM_W'(1) << 24;
	localparam logic [SUM_W-1:0] DIV_INIT = SUM_W'(1) << (RECIP_SHIFT - RECIP_STEPS);

	logic [SQ_W-1:0]        sqx_q;
	logic [SQ_W-1:0]        sqz_q;

	logic [SUM_W-1:0]       dd_q [0:RECIP_STEPS];
	logic [SUM_W-1:0]       rr_q [0:RECIP_STEPS];
	logic [RECIP_STEPS-1:0] qq_q [0:RECIP_STEPS];
	logic [SUM_W-1:0]       drem [0:RECIP_STEPS-1];
	logic                   dbit [0:RECIP_STEPS-1];
	logic [SUM_W:0]         dtrial [0:RECIP_STEPS-1];

	logic [SQ_IN_W-1:0]     xs_q  [1:SQRT_STEPS];
	logic [SR_W-1:0]        sr_q  [1:SQRT_STEPS];
	logic [SQRT_STEPS-1:0]  res_q [1:SQRT_STEPS];
	logic [SQ_IN_W-1:0]     xin   [0:SQRT_STEPS-1];
	logic [SR_W-1:0]        rin   [0:SQRT_STEPS-1];
	logic [SQRT_STEPS-1:0]  resin [0:SQRT_STEPS-1];
	logic [SR_W+1:0]        strial[0:SQRT_STEPS-1];
	logic [SR_W+1:0]        sbase [0:SQRT_STEPS-1];
	logic [SR_W-1:0]        srnew [0:SQRT_STEPS-1];
	logic                   sbit  [0:SQRT_STEPS-1];
	logic [SQRT_STEPS-1:0]  inv;

	// Reciprocal divider, one quotient bit per stage.
	always_comb begin
		for (int k = 0; k < RECIP_STEPS; k++) begin
			dtrial[k] = {rr_q[k], 1'b0};
			if (dtrial[k] >= {1'b0, dd_q[k]}) begin
				dbit[k] = 1'b1;
				drem[k] = SUM_W'(dtrial[k] - {1'b0, dd_q[k]});
			end else begin
				dbit[k] = 1'b0;
				drem[k] = dtrial[k][SUM_W-1:0];
			end
		end
	end

	// Square root, two radicand bits per stage.
	always_comb begin
		for (int k = 0; k < SQRT_STEPS; k++) begin
			if (k == 0) begin
				xin[k]   = SQ_IN_W'(qq_q[RECIP_STEPS]);
				rin[k]   = '0;
				resin[k] = '0;
			end else begin
				xin[k]   = xs_q[k];
				rin[k]   = sr_q[k];
				resin[k] = res_q[k];
			end
			strial[k] = {rin[k], xin[k][SQ_IN_W-1:SQ_IN_W-2]};
			sbase[k]  = (SR_W+2)'({resin[k], 2'b01});
			if (strial[k] >= sbase[k]) begin
				sbit[k]  = 1'b1;
				srnew[k] = SR_W'(strial[k] - sbase[k]);
			end else begin
				sbit[k]  = 1'b0;
				srnew[k] = strial[k][SR_W-1:0];
			end
		end
	end

	assign inv = res_q[SQRT_STEPS];

	always_ff @(posedge clk) begin
		if (en) begin
			// Squares of the gradients.
			sqx_q <= SQ_W'(gx) * SQ_W'(gx);
			sqz_q <= SQ_W'(gz) * SQ_W'(gz);

			// S = 1 + dx^2 + dz^2 in Q.24; divider set-up.
			dd_q[0] <= ONE_Q24 + sqx_q + sqz_q;
			rr_q[0] <= DIV_INIT;
			qq_q[0] <= '0;
			for (int k = 0; k < RECIP_STEPS; k++) begin
				dd_q[k+1] <= dd_q[k];
				rr_q[k+1] <= drem[k];
				qq_q[k+1] <= {qq_q[k][RECIP_STEPS-2:0], dbit[k]};
			end

			for (int k = 0; k < SQRT_STEPS; k++) begin
				xs_q[k+1]  <= xin[k] << 2;
				sr_q[k+1]  <= srnew[k];
				res_q[k+1] <= {resin[k][SQRT_STEPS-2:0], sbit[k]};
			end

			// One minus the inverse root, saturated to 16 bits.
			if (inv == '0) begin
				slope <= '1;
			end else if (inv[SQRT_STEPS-1]) begin
				slope <= '0;
			end else begin
				slope <= FIX_W'({1'b1, {FIX_W{1'b0}}} - inv);
			end
		end
	end

endmodule

`default_nettype wire

// File: sim/heightmap_slope_mask_test.sv
// Self-checking testbench for heightmap_slope_mask: raster frames with random
// sizes, spacings and scales, random idling and one long output hold.
// Depends on hsm_pkg and the heightmap_slope_mask RTL.
`timescale 1ns / 1ps

module heightmap_slope_mask_test;
	import hsm_pkg::*;

	localparam int LATENCY_WAIT = 120;
	localparam int IDLE_LIMIT   = 5000;
	localparam int HOLD_CYCLES  = 300;
	localparam int RANDOM_WORDS = 1400;

	typedef struct packed {
		logic [FIX_W-1:0] slope;
		logic             row_end;
		logic             frame_end;
	} slope_word_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_write = 1'b0;
	logic [IDX_W-1:0]    cfg_index = '0;
	logic [FIX_W-1:0]    cfg_data = '0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [SAMPLE_W-1:0] height_sample = '0;
	logic                flush = 1'b0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [FIX_W-1:0]    slope;
	logic                row_end;
	logic                frame_end;

	heightmap_slope_mask u_dut (.*);

	// Predicted state of the block.
	int          mid_line [ROW_MAX];
	int          top_line [ROW_MAX];
	int unsigned col_pos = 0;
	int unsigned row_pos = 0;
	logic [12:0] cur_row_length = 13'd4096;
	logic [12:0] cur_row_count = 13'd4096;
	logic [15:0] cur_spacing_x = 16'd256;
	logic [15:0] cur_spacing_z = 16'd256;
	logic [15:0] cur_scale = 16'd256;

	slope_word_t pending_slopes [$];
	int          errors = 0;
	int          words_sent = 0;
	bit          calm = 1'b0;
	int          hold_req = 0;

	initial begin
		forever #1 clk = ~clk;
	end

	// Scaled and saturated gradient magnitude in Q.12.
	function automatic longint unsigned grad_q12(longint a, longint b, int unsigned span,
			logic [15:0] spacing, longint unsigned mag);
		longint unsigned d;
		longint unsigned den;
		longint unsigned q;
		d = (a >= b) ? longint'(a - b) : longint'(b - a);
		den = longint'(span) * ((spacing == 0) ? 64'd1 : longint'(spacing));
		q = ((d * mag) << 12) / den;
		return (q > (64'd1 << 28)) ? (64'd1 << 28) : q;
	endfunction

	function automatic longint unsigned int_root(longint unsigned x);
		longint unsigned res;
		longint unsigned bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > x) bitv >>= 2;
		while (bitv != 0) begin
			if (x >= res + bitv) begin
				x -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic int unsigned eff_width();
		if (cur_row_length == 0) return 1;
		if (cur_row_length > ROW_MAX) return ROW_MAX;
		return 32'(cur_row_length);
	endfunction

	function automatic int unsigned eff_height();
		if (cur_row_count == 0) return 1;
		if (cur_row_count > ROW_LIMIT) return ROW_LIMIT;
		return 32'(cur_row_count);
	endfunction

	// Advance the predicted state by one accepted word and queue its slope.
	task automatic predict_slope(input logic [15:0] smp, input logic fl);
		int unsigned w;
		int unsigned h;
		int unsigned c;
		int unsigned r;
		bit draining;
		bit last_col;
		longint s_val;
		longint center;
		longint lft;
		longint rgt;
		longint up;
		longint dn;
		longint unsigned mag;
		longint unsigned gx;
		longint unsigned gz;
		longint unsigned inv;
		longint unsigned sl;
		int unsigned hspan;
		int unsigned vspan;
		slope_word_t res;
		w = eff_width();
		h = eff_height();
		draining = row_pos >= h;
		if (fl != draining) return;
		s_val = fl ? 0 : longint'($signed(smp));
		c = col_pos;
		r = row_pos;
		last_col = (col_pos + 1 >= w);
		if (r == 0) begin
			mid_line[c] = int'(s_val);
		end else begin
			center = mid_line[c];
			hspan = 32'(c >= 1) + 32'(c + 1 < w);
			vspan = 32'(r >= 2) + 32'(!draining);
			lft = (c >= 1) ? top_line[c-1] : center;
			rgt = (c + 1 < w) ? mid_line[c+1] : center;
			up = (r >= 2) ? top_line[c] : center;
			dn = draining ? center : s_val;
			mag = ($signed(cur_scale) < 0) ? longint'(-$signed(cur_scale)) :
				longint'($signed(cur_scale));
			gx = (hspan != 0) ? grad_q12(rgt, lft, hspan, cur_spacing_x, mag) : 0;
			gz = (vspan != 0) ? grad_q12(dn, up, vspan, cur_spacing_z, mag) : 0;
			inv = int_root((64'd1 << 56) / ((64'd1 << 24) + gx * gx + gz * gz));
			sl = (inv >= 65536) ? 0 : 65536 - inv;
			if (sl > 65535) sl = 65535;
			top_line[c] = int'(center);
			if (!draining) mid_line[c] = int'(s_val);
			res.slope = sl[15:0];
			res.row_end = last_col;
			res.frame_end = last_col && draining;
			pending_slopes.push_back(res);
		end
		if (last_col) begin
			col_pos = 0;
			row_pos = draining ? 0 : row_pos + 1;
		end else begin
			col_pos++;
		end
	endtask

	// Offer one word and wait until it is accepted.
	task automatic send_word(input logic [15:0] smp, input logic fl);
		in_valid <= 1'b1;
		height_sample <= smp;
		flush <= fl;
		@(negedge clk);
		while (in_stall) @(negedge clk);
		@(posedge clk);
		predict_slope(smp, fl);
		if (!calm && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	// Register write once the block has drained.
	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [15:0] val);
		in_valid <= 1'b0;
		while (pending_slopes.size() != 0) @(posedge clk);
		repeat (LATENCY_WAIT) @(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_write <= 1'b0;
		case (idx)
			REG_ROW_LENGTH:   cur_row_length = val[12:0];
			REG_ROW_COUNT:    cur_row_count = val[12:0];
			REG_SPACING_X:    cur_spacing_x = val;
			REG_SPACING_Z:    cur_spacing_z = val;
			REG_HEIGHT_SCALE: cur_scale = val;
			default: ;
		endcase
	endtask

	task automatic set_frame(input logic [15:0] len, input logic [15:0] cnt,
			input logic [15:0] sx, input logic [15:0] sz, input logic [15:0] sc);
		write_reg(REG_ROW_LENGTH, len);
		write_reg(REG_ROW_COUNT, cnt);
		write_reg(REG_SPACING_X, sx);
		write_reg(REG_SPACING_Z, sz);
		write_reg(REG_HEIGHT_SCALE, sc);
	endtask

	function automatic logic [15:0] pick_sample();
		case ($urandom_range(0, 9))
			0, 1:    return 16'($urandom);
			2:       return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
			default: return 16'($urandom_range(0, 200) - 100);
		endcase
	endfunction

	// Whole frame plus its drain row; stray words are optionally mixed in.
	task automatic run_frame(input bit noisy);
		int unsigned w;
		int unsigned h;
		w = eff_width();
		h = eff_height();
		for (int i = 0; i < w * h; i++) begin
			if (noisy && $urandom_range(0, 29) == 0) send_word(16'($urandom), 1'b1);
			send_word(pick_sample(), 1'b0);
			words_sent++;
		end
		for (int i = 0; i < w; i++) begin
			if (noisy && $urandom_range(0, 29) == 0) send_word(16'($urandom), 1'b0);
			send_word(16'($urandom), 1'b1);
			words_sent++;
		end
	endtask

	// Extreme samples, steepest and flattest settings, degenerate sizes.
	task automatic test_directed();
		set_frame(16'd4, 16'd3, 16'd1, 16'd65535, 16'h8000);
		send_word(16'h1234, 1'b1);
		send_word(16'h8000, 1'b0); send_word(16'h7fff, 1'b0);
		send_word(16'h0000, 1'b0); send_word(16'hffff, 1'b0);
		send_word(16'h7fff, 1'b0); send_word(16'h8000, 1'b0);
		send_word(16'h0001, 1'b0); send_word(16'h8000, 1'b0);
		send_word(16'h0000, 1'b0); send_word(16'h5555, 1'b0);
		send_word(16'haaaa, 1'b0); send_word(16'h0000, 1'b0);
		send_word(16'h4321, 1'b0);
		for (int i = 0; i < 4; i++) send_word(16'hffff, 1'b1);
		set_frame(16'd0, 16'd0, 16'd0, 16'd0, 16'h7fff);
		send_word(16'h7fff, 1'b0);
		send_word(16'h0000, 1'b1);
	endtask

	// Random frame shapes and register values.
	task automatic test_random_frames();
		while (words_sent < RANDOM_WORDS) begin
			if (words_sent > RANDOM_WORDS - 300) calm = 1'b1;
			set_frame(16'($urandom_range(1, 24)), 16'($urandom_range(1, 6)),
				$urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 1024)),
				$urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 1024)),
				$urandom_range(0, 2) == 0 ? 16'($urandom) :
					16'($urandom_range(0, 1024) - 512));
			run_frame(!calm);
		end
	endtask

	// The receiver holds off while words keep arriving.
	task automatic test_output_hold();
		set_frame(16'd16, 16'd20, 16'd256, 16'd128, 16'd300);
		hold_req++;
		run_frame(1'b0);
	endtask

	// Wide rows, then a tall frame one pixel wide.
	task automatic test_size_limits();
		set_frame(16'd96, 16'd2, 16'd256, 16'd256, 16'd256);
		run_frame(1'b0);
		set_frame(16'd1, 16'd48, 16'd200, 16'd300, 16'hff00);
		run_frame(1'b0);
	endtask

	// Output side: random stall bursts plus the requested long hold.
	int stall_left = 0;
	int hold_seen = 0;
	always @(posedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			stall_left = HOLD_CYCLES;
		end
		if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (!calm && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(0, 4);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Compare each accepted slope word with the oldest prediction.
	always @(posedge clk) begin
		slope_word_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_slopes.size() == 0) begin
				$error("unexpected word: slope %0d row_end %0d frame_end %0d",
					slope, row_end, frame_end);
				errors++;
			end else begin
				want = pending_slopes.pop_front();
				if (slope !== want.slope) begin
					$error("slope: expected %0d, got %0d", want.slope, slope);
					errors++;
				end
				if (row_end !== want.row_end) begin
					$error("row_end: expected %0d, got %0d", want.row_end, row_end);
					errors++;
				end
				if (frame_end !== want.frame_end) begin
					$error("frame_end: expected %0d, got %0d", want.frame_end, frame_end);
					errors++;
				end
			end
		end
	end

	// Watchdog on cycles with no word moving on either side.
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("heightmap_slope_mask test failed");
			$finish;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_output_hold();
		test_size_limits();
		test_random_frames();
		in_valid <= 1'b0;
		while (pending_slopes.size() != 0) @(posedge clk);
		repeat (LATENCY_WAIT) @(posedge clk);
		if (errors == 0) begin
			$display("heightmap_slope_mask test passed");
		end else begin
			$display("heightmap_slope_mask test failed");
		end
		$finish;
	end

endmodule
